// File: rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // one queued task
    typedef struct packed {
        logic [7:0]  remaining;
        logic [31:0] arrival;
        logic [31:0] wait_ticks;
    } entry_t;

    // request payload
    typedef struct packed {
        logic       new_task_valid;
        logic [7:0] new_task_length;
    } task_req_t;

    // result payload
    typedef struct packed {
        logic        busy_res;
        logic        task_done;
        logic [31:0] done_arrival_tick;
        logic [31:0] done_wait_ticks;
        logic [31:0] done_finish_tick;
        logic        arrival_dropped;
        logic [31:0] idle_ticks;
    } result_t;

endpackage

// File: rtl/mlfq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_cell
// One slot of a level queue: shifts towards the head on a pop, loads a new
// entry when it is the first free slot, ages its wait count on busy ticks.
// ----------------------------------------------------------------------------
module mlfq_cell
    import mlfq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  logic   up_valid,
    input  entry_t up_entry,
    input  logic   prev_post_valid,
    input  logic   load_en,
    input  entry_t load_entry,
    input  logic   age,
    output logic   valid,
    output entry_t entry,
    output logic   post_valid
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    entry_t post_entry;
    logic   load;

    // contents after the head pop
    assign post_valid = shift ? up_valid : valid_reg;
    assign post_entry = shift ? up_entry : entry_reg;
    assign load       = load_en && !post_valid && prev_post_valid;

    // aged or freshly loaded contents
    always_comb
    begin
        valid_next = post_valid;
        entry_next = post_entry;
        if (post_valid && age && (post_entry.wait_ticks != 32'hFFFF_FFFF))
        begin
            entry_next.wait_ticks = post_entry.wait_ticks + 32'd1;
        end
        if (load)
        begin
            valid_next = 1'b1;
            entry_next = load_entry;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// File: rtl/mlfq_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_level
// One priority level: a row of cells, head at cell 0, tail filling upwards.
// ----------------------------------------------------------------------------
module mlfq_level
    import mlfq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pop,
    input  logic   load_en,
    input  entry_t load_entry,
    input  logic   age,
    output logic   head_valid,
    output entry_t head_entry,
    output logic   full
);

    logic   cell_valid [QUEUE_DEPTH];
    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_post  [QUEUE_DEPTH];

    // row of cells, each fed by its upper neighbour
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        logic   up_v;
        entry_t up_e;
        logic   prev_pv;

        if (k == QUEUE_DEPTH - 1)
        begin : g_top
            assign up_v = 1'b0;
            assign up_e = '0;
        end
        else
        begin : g_mid
            assign up_v = cell_valid[k + 1];
            assign up_e = cell_entry[k + 1];
        end

        if (k == 0)
        begin : g_head
            assign prev_pv = 1'b1;
        end
        else
        begin : g_tail
            assign prev_pv = cell_post[k - 1];
        end

        mlfq_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .shift           (pop),
            .up_valid        (up_v),
            .up_entry        (up_e),
            .prev_post_valid (prev_pv),
            .load_en         (load_en),
            .load_entry      (load_entry),
            .age             (age),
            .valid           (cell_valid[k]),
            .entry           (cell_entry[k]),
            .post_valid      (cell_post[k])
        );
    end

    assign head_valid = cell_valid[0];
    assign head_entry = cell_entry[0];
    assign full       = cell_valid[QUEUE_DEPTH - 1];

endmodule

// File: rtl/multilevel_feedback_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_unit
// Multilevel feedback queue scheduler, one scheduler tick per request.
// ----------------------------------------------------------------------------
//  channel   signals                               carries
//  request   task_valid / task_ready / task_req    one tick, optional new task
//  result    result_valid / result_ready / result  tick outcome, one per request
//
//  One request is processed per clock while results are taken: the queue cells
//  shift, load and age in parallel, and the run state updates in the same cycle.
//  The result sits in an output register; a new request is taken whenever
//  that register is empty or is being taken in the same cycle.
//  Reset clears all queues at once; no request is needed to settle.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_unit
    import mlfq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    output logic      task_ready,
    input  task_req_t task_req,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result
);

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);

    logic             head_valid [NUM_LEVELS];
    entry_t           head_entry [NUM_LEVELS];
    logic             lvl_full   [NUM_LEVELS];
    logic             lvl_pop    [NUM_LEVELS];
    logic             lvl_load   [NUM_LEVELS];
    entry_t           lvl_data   [NUM_LEVELS];

    logic             run_active_reg,    run_active_next;
    logic [7:0]       run_remaining_reg, run_remaining_next;
    logic [7:0]       run_slice_reg,     run_slice_next;
    logic [LVL_W-1:0] run_level_reg,     run_level_next;
    logic [31:0]      run_arrival_reg,   run_arrival_next;
    logic [31:0]      run_wait_reg,      run_wait_next;
    logic [31:0]      tick_reg,          tick_next;
    logic [31:0]      idle_reg,          idle_next;
    logic             out_valid_reg;
    result_t          out_reg,           out_next;

    logic             accept;
    logic             arrive;
    logic             arrive_ok;
    logic             any_ready;
    logic             start;
    logic [LVL_W-1:0] pop_lvl;
    logic             take_arrival;
    entry_t           arr_entry;
    entry_t           pop_entry;
    logic [7:0]       cur_rem;
    logic [7:0]       cur_slice;
    logic [LVL_W-1:0] cur_lvl;
    logic [31:0]      cur_arr;
    logic [31:0]      cur_wait;
    logic [7:0]       lvl_plus;
    logic             busy;
    logic [7:0]       rem_dec;
    logic [7:0]       slice_dec;
    logic             done;
    logic             demote;
    logic [LVL_W-1:0] dem_lvl;
    entry_t           dem_entry;

    // handshake
    assign task_ready   = !out_valid_reg || result_ready;
    assign accept       = task_valid && task_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // arrival check against level 0
    assign arrive    = accept && task_req.new_task_valid;
    assign arrive_ok = arrive && (task_req.new_task_length != 8'd0) && !lvl_full[0];
    assign arr_entry = '{remaining: task_req.new_task_length, arrival: tick_reg,
                         wait_ticks: 32'd0};

    // highest-priority non-empty level
    always_comb
    begin
        any_ready = 1'b0;
        pop_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (head_valid[l] || ((l == 0) && arrive_ok))
            begin
                any_ready = 1'b1;
                pop_lvl   = LVL_W'(l);
            end
        end
    end

    assign start        = accept && !run_active_reg && any_ready;
    assign take_arrival = start && (pop_lvl == '0) && !head_valid[0];
    assign pop_entry    = take_arrival ? arr_entry : head_entry[pop_lvl];

    // running task for this tick
    assign lvl_plus = 8'(pop_lvl) + 8'd1;
    always_comb
    begin
        if (start)
        begin
            cur_rem  = pop_entry.remaining;
            cur_lvl  = pop_lvl;
            cur_arr  = pop_entry.arrival;
            cur_wait = pop_entry.wait_ticks;
            if ((pop_lvl == LAST_LVL) || (pop_entry.remaining <= lvl_plus))
            begin
                cur_slice = pop_entry.remaining;
            end
            else
            begin
                cur_slice = lvl_plus;
            end
        end
        else
        begin
            cur_rem   = run_remaining_reg;
            cur_slice = run_slice_reg;
            cur_lvl   = run_level_reg;
            cur_arr   = run_arrival_reg;
            cur_wait  = run_wait_reg;
        end
    end

    assign busy      = accept && (run_active_reg || start);
    assign rem_dec   = cur_rem - 8'd1;
    assign slice_dec = cur_slice - 8'd1;
    assign done      = busy && (rem_dec == 8'd0);
    assign demote    = busy && !done && (slice_dec == 8'd0) && (cur_lvl != LAST_LVL);
    assign dem_lvl   = cur_lvl + LVL_W'(1);
    assign dem_entry = '{remaining: rem_dec, arrival: cur_arr, wait_ticks: cur_wait};

    // per-level pop and load
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            lvl_pop[l] = start && (pop_lvl == LVL_W'(l)) && head_valid[l];
            if (l == 0)
            begin
                lvl_load[l]            = arrive_ok && !take_arrival;
                lvl_data[l]            = arr_entry;
                lvl_data[l].wait_ticks = busy ? 32'd1 : 32'd0;
            end
            else
            begin
                lvl_load[l] = demote && (dem_lvl == LVL_W'(l)) && !lvl_full[l];
                lvl_data[l] = dem_entry;
            end
        end
    end

    for (genvar l = 0; l < NUM_LEVELS; l++)
    begin : g_level
        mlfq_level u_level (
            .clk        (clk),
            .rst_n      (rst_n),
            .pop        (lvl_pop[l]),
            .load_en    (lvl_load[l]),
            .load_entry (lvl_data[l]),
            .age        (busy),
            .head_valid (head_valid[l]),
            .head_entry (head_entry[l]),
            .full       (lvl_full[l])
        );
    end

    // run state and counters
    always_comb
    begin
        run_active_next    = run_active_reg;
        run_remaining_next = run_remaining_reg;
        run_slice_next     = run_slice_reg;
        run_level_next     = run_level_reg;
        run_arrival_next   = run_arrival_reg;
        run_wait_next      = run_wait_reg;
        tick_next          = tick_reg;
        idle_next          = idle_reg;
        if (accept)
        begin
            tick_next = tick_reg + 32'd1;
            if (busy)
            begin
                run_active_next    = !done && (slice_dec != 8'd0);
                run_remaining_next = rem_dec;
                run_slice_next     = done ? 8'd0 : slice_dec;
                run_level_next     = demote ? dem_lvl : cur_lvl;
                run_arrival_next   = cur_arr;
                run_wait_next      = cur_wait;
            end
            else
            begin
                idle_next = idle_reg + 32'd1;
            end
        end
    end

    // result of this tick
    always_comb
    begin
        out_next                   = '0;
        out_next.busy_res          = busy;
        out_next.task_done         = done;
        out_next.arrival_dropped   = arrive && !arrive_ok;
        out_next.idle_ticks        = idle_next;
        if (done)
        begin
            out_next.done_arrival_tick = cur_arr;
            out_next.done_wait_ticks   = cur_wait;
            out_next.done_finish_tick  = tick_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg    <= 1'b0;
            run_remaining_reg <= '0;
            run_slice_reg     <= '0;
            run_level_reg     <= '0;
            run_arrival_reg   <= '0;
            run_wait_reg      <= '0;
            tick_reg          <= 32'd1;
            idle_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            run_active_reg    <= run_active_next;
            run_remaining_reg <= run_remaining_next;
            run_slice_reg     <= run_slice_next;
            run_level_reg     <= run_level_next;
            run_arrival_reg   <= run_arrival_next;
            run_wait_reg      <= run_wait_next;
            tick_reg          <= tick_next;
            idle_reg          <= idle_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule
